FILE: rtl/pfi_pkg.sv
// Package for the particle force integrator: opcodes, sequencer states and
// small saturating helpers. Depends on nothing; only particle_force_integrate uses it.
package pfi_pkg;

    typedef enum logic [2:0] {
        OP_CLEAR     = 3'd0,
        OP_DAMP      = 3'd1,
        OP_REPEL     = 3'd2,
        OP_ATTRACT   = 3'd3,
        OP_INTEGRATE = 3'd4,
        OP_TRAIL     = 3'd5
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SQX,
        ST_SQY,
        ST_SQR,
        ST_SQRT,
        ST_PCT,
        ST_UNIT,
        ST_MUL1,
        ST_MUL2,
        ST_ACCUM,
        ST_DAMPX,
        ST_DAMPY,
        ST_WRITE
    } state_t;

    // Damping gain is a fixed Q0.16 factor, independent of the data format.
    localparam int GAIN_W = 16;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd5898;

    localparam logic signed [35:0] SAT_MAX = 36'sh0_7FFF_FFFF;
    localparam logic signed [35:0] SAT_MIN = -36'sh0_8000_0000;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < SAT_MIN)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [35:0] ext36(input logic signed [31:0] v);
        return {{4{v[31]}}, v};
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

endpackage

FILE: rtl/pfi_if.sv
// Handshake interfaces for the command and result channels.
// Depends on nothing.
interface pfi_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic               set_state;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic [30:0]        radius;
    logic signed [31:0] strength;

    modport source (output valid, opcode, set_state, point_x, point_y, new_vel_x,
                    new_vel_y, radius, strength, input ready);
    modport sink (input valid, opcode, set_state, point_x, point_y, new_vel_x,
                  new_vel_y, radius, strength, output ready);
endinterface

interface pfi_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               in_range;

    modport source (output valid, pos_x, pos_y, vel_x, vel_y, in_range, input ready);
    modport sink (input valid, pos_x, pos_y, vel_x, vel_y, in_range, output ready);
endinterface

FILE: rtl/pfi_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on nothing.
module pfi_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [AW-1:0]      a,
    input  logic [BW-1:0]      b,
    output logic               done,
    output logic [AW+BW-1:0]   product
);
    localparam int CW = $clog2(BW + 1);

    logic [AW-1:0]    a_reg;
    logic [AW+BW-1:0] acc_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [AW:0]      sum;

    // The low half of the accumulator holds the multiplier bits not yet used.
    assign sum = {1'b0, acc_reg[AW+BW-1:BW]} + (acc_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(BW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            acc_reg <= {{AW{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            acc_reg <= {sum, acc_reg[BW-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

FILE: rtl/pfi_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing.
module pfi_div #(
    parameter int NW = 47,
    parameter int DW = 31
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quotient
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] nq_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    // nq_reg shifts dividend bits out at the top and quotient bits in below.
    assign trial = {rem_reg, nq_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg  <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            nq_reg  <= {nq_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = nq_reg;
endmodule

FILE: rtl/pfi_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on nothing.
module pfi_sqrt #(
    parameter int RW = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [2*RW-1:0] radicand,
    output logic            done,
    output logic [RW-1:0]   root
);
    localparam int CW = $clog2(RW + 1);

    logic [2*RW-1:0] rad_reg;
    logic [RW+1:0]   rem_reg;
    logic [RW-1:0]   root_reg;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [RW+3:0]   shifted;
    logic [RW+3:0]   trial;
    logic [RW+3:0]   diff;
    logic            ge;

    assign shifted = {rem_reg, rad_reg[2*RW-1:2*RW-2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign diff    = shifted - trial;
    assign ge      = shifted >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(RW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[2*RW-3:0], 2'b00};
            rem_reg  <= ge ? diff[RW+1:0] : shifted[RW+1:0];
            root_reg <= {root_reg[RW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

FILE: rtl/particle_force_integrate.sv
// Top level of the particle force integrator: state registers, sequencer and
// the shared serial units. Depends on pfi_pkg, pfi_if, pfi_mul, pfi_div, pfi_sqrt.
//
//   channel | dir | transaction
//   cmd     | in  | one command (opcode or state load) per transaction
//   res     | out | position, velocity and in_range after that command
//   cfg     | in  | damping gain write, taken whenever cfg_we is high
//
// One command at a time. Clear, set, integrate and trail use no serial unit.
// Damp runs two 32-step products on the serial multiplier. Repel and attract
// run up to seven serial products, one 32-step square root and three
// (FRAC_BITS+31)-step divisions. A stalled result lets the next command run
// up to its write step, where it waits until the result is taken. Reset
// clears the particle state to zero.
module particle_force_integrate #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    pfi_cmd_if.sink       cmd,
    pfi_res_if.source     res,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata
);
    localparam int NW = 31 + FRAC_BITS;
    localparam int QW = FRAC_BITS + 1;

    pfi_pkg::state_t state_reg, state_next;

    logic [pfi_pkg::GAIN_W-1:0] gain_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;
    logic signed [31:0] frc_x_reg, frc_y_reg;

    logic [2:0]         op_reg;
    logic               set_reg;
    logic signed [31:0] pt_x_reg, pt_y_reg, nv_x_reg, nv_y_reg, str_reg;
    logic [30:0]        rad_reg;

    logic signed [32:0] dx_reg, dy_reg;
    logic [62:0]        ssum_reg;
    logic [30:0]        dist_reg;
    logic [QW-1:0]      pct_reg, unit_reg, m_reg;
    logic [31:0]        mag_reg;
    logic               axis_reg;
    logic               hit_reg;
    logic               launched_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_px_reg, out_py_reg, out_vx_reg, out_vy_reg;
    logic               out_hit_reg;

    logic               mul_start, div_start, sqrt_start;
    logic               mul_done, div_done, sqrt_done;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;
    logic [NW-1:0]      div_num, div_q;
    logic [30:0]        div_den;
    logic [31:0]        sqrt_root;

    logic signed [32:0] dx_c, dy_c;
    logic [32:0]        adx_c, ady_c, adx, ady;
    logic               far_c;
    logic               out_free;
    logic [31:0]        astr;
    logic               is_radial, is_damp;
    logic               near_c;

    logic signed [31:0] vel_damp;
    logic [31:0]        avel;
    logic signed [49:0] sprod;
    logic signed [49:0] biased;
    logic signed [35:0] damp_sum;
    logic signed [31:0] frc_axis;
    logic               neg_radial;
    logic signed [35:0] radial_sum;

    logic signed [31:0] px_new, py_new, vx_new, vy_new;
    logic signed [32:0] trail_x, trail_y;

    assign is_radial = (op_reg == pfi_pkg::OP_REPEL) || (op_reg == pfi_pkg::OP_ATTRACT);
    assign is_damp   = (op_reg == pfi_pkg::OP_DAMP);

    assign dx_c  = {pos_x_reg[31], pos_x_reg} - {pt_x_reg[31], pt_x_reg};
    assign dy_c  = {pos_y_reg[31], pos_y_reg} - {pt_y_reg[31], pt_y_reg};
    assign adx_c = pfi_pkg::mag33(dx_c);
    assign ady_c = pfi_pkg::mag33(dy_c);
    // Any axis offset of 2^31 or more is out of range outright.
    assign far_c = adx_c[32] | adx_c[31] | ady_c[32] | ady_c[31];
    assign adx   = pfi_pkg::mag33(dx_reg);
    assign ady   = pfi_pkg::mag33(dy_reg);
    assign astr  = str_reg[31] ? 32'(-str_reg) : 32'(str_reg);
    assign near_c = (ssum_reg < mul_p[62:0]) && (ssum_reg != '0);

    assign out_free  = !out_valid_reg || res.ready;
    assign cmd.ready = (state_reg == pfi_pkg::ST_IDLE);

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfi_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        unique case (state_reg)
            pfi_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = pfi_pkg::ST_DECODE;
                end
            end
            pfi_pkg::ST_DECODE:
            begin
                if (set_reg)
                begin
                    state_next = pfi_pkg::ST_WRITE;
                end
                else if (is_damp)
                begin
                    state_next = pfi_pkg::ST_DAMPX;
                end
                else if (is_radial && !far_c)
                begin
                    state_next = pfi_pkg::ST_SQX;
                end
                else
                begin
                    state_next = pfi_pkg::ST_WRITE;
                end
            end
            pfi_pkg::ST_SQX:
            begin
                mul_start = !launched_reg;
                if (mul_done)
                begin
                    state_next = pfi_pkg::ST_SQY;
                end
            end
            pfi_pkg::ST_SQY:
            begin
                mul_start = !launched_reg;
                if (mul_done)
                begin
                    state_next = pfi_pkg::ST_SQR;
                end
            end
            pfi_pkg::ST_SQR:
            begin
                mul_start = !launched_reg;
                if (mul_done)
                begin
                    state_next = near_c ? pfi_pkg::ST_SQRT : pfi_pkg::ST_WRITE;
                end
            end
            pfi_pkg::ST_SQRT:
            begin
                sqrt_start = !launched_reg;
                if (sqrt_done)
                begin
                    state_next = pfi_pkg::ST_PCT;
                end
            end
            pfi_pkg::ST_PCT:
            begin
                div_start = !launched_reg;
                if (div_done)
                begin
                    state_next = pfi_pkg::ST_UNIT;
                end
            end
            pfi_pkg::ST_UNIT:
            begin
                div_start = !launched_reg;
                if (div_done)
                begin
                    state_next = pfi_pkg::ST_MUL1;
                end
            end
            pfi_pkg::ST_MUL1:
            begin
                mul_start = !launched_reg;
                if (mul_done)
                begin
                    state_next = pfi_pkg::ST_MUL2;
                end
            end
            pfi_pkg::ST_MUL2:
            begin
                mul_start = !launched_reg;
                if (mul_done)
                begin
                    state_next = pfi_pkg::ST_ACCUM;
                end
            end
            pfi_pkg::ST_ACCUM:
            begin
                state_next = axis_reg ? pfi_pkg::ST_WRITE : pfi_pkg::ST_UNIT;
            end
            pfi_pkg::ST_DAMPX:
            begin
                mul_start = !launched_reg;
                if (mul_done)
                begin
                    state_next = pfi_pkg::ST_DAMPY;
                end
            end
            pfi_pkg::ST_DAMPY:
            begin
                mul_start = !launched_reg;
                if (mul_done)
                begin
                    state_next = pfi_pkg::ST_WRITE;
                end
            end
            pfi_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = pfi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfi_pkg::ST_IDLE;
            end
        endcase
    end

    // Operand selection for the shared units.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            pfi_pkg::ST_SQX:
            begin
                mul_a = adx[31:0];
                mul_b = adx[31:0];
            end
            pfi_pkg::ST_SQY:
            begin
                mul_a = ady[31:0];
                mul_b = ady[31:0];
            end
            pfi_pkg::ST_SQR:
            begin
                mul_a = {1'b0, rad_reg};
                mul_b = {1'b0, rad_reg};
            end
            pfi_pkg::ST_MUL1:
            begin
                mul_a = 32'(unit_reg);
                mul_b = 32'(pct_reg);
            end
            pfi_pkg::ST_MUL2:
            begin
                mul_a = 32'(m_reg);
                mul_b = astr;
            end
            pfi_pkg::ST_DAMPX, pfi_pkg::ST_DAMPY:
            begin
                mul_a = avel;
                mul_b = 32'(gain_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == pfi_pkg::ST_PCT)
        begin
            div_num = {rad_reg - dist_reg, {FRAC_BITS{1'b0}}};
        end
        else if (axis_reg)
        begin
            div_num = {ady[30:0], {FRAC_BITS{1'b0}}};
        end
        else
        begin
            div_num = {adx[30:0], {FRAC_BITS{1'b0}}};
        end
    end

    assign div_den = (state_reg == pfi_pkg::ST_PCT) ? rad_reg : dist_reg;

    pfi_mul #(.AW(32), .BW(32)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    pfi_div #(.NW(NW), .DW(31)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    pfi_sqrt #(.RW(32)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({1'b0, ssum_reg}),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Damping: the product is rounded half up, then subtracted from the force.
    assign vel_damp = (state_reg == pfi_pkg::ST_DAMPY) ? vel_y_reg : vel_x_reg;
    assign avel     = vel_damp[31] ? 32'(-vel_damp) : 32'(vel_damp);
    assign frc_axis = (state_reg == pfi_pkg::ST_DAMPY) ? frc_y_reg :
                      ((state_reg == pfi_pkg::ST_ACCUM) && axis_reg) ? frc_y_reg : frc_x_reg;
    assign sprod    = vel_damp[31] ? -$signed({2'b00, mul_p[47:0]})
                                   : $signed({2'b00, mul_p[47:0]});
    assign biased   = sprod + 50'sd32768;
    assign damp_sum = pfi_pkg::ext36(frc_axis) - {{2{biased[49]}}, biased[49:16]};

    // Radial term: sign of the offset times sign of the strength, flipped for attract.
    assign neg_radial = (axis_reg ? dy_reg[32] : dx_reg[32]) ^ str_reg[31]
                        ^ (op_reg == pfi_pkg::OP_ATTRACT);
    assign radial_sum = pfi_pkg::ext36(frc_axis)
                        + (neg_radial ? -$signed({4'b0000, mag_reg})
                                      : $signed({4'b0000, mag_reg}));

    // Final state update for set, integrate and trail, applied in the write step.
    assign trail_x = {pt_x_reg[31], pt_x_reg} + {pos_x_reg[31], pos_x_reg};
    assign trail_y = {pt_y_reg[31], pt_y_reg} + {pos_y_reg[31], pos_y_reg};

    always_comb
    begin
        px_new = pos_x_reg;
        py_new = pos_y_reg;
        vx_new = vel_x_reg;
        vy_new = vel_y_reg;
        if (set_reg)
        begin
            px_new = pt_x_reg;
            py_new = pt_y_reg;
            vx_new = nv_x_reg;
            vy_new = nv_y_reg;
        end
        else if (op_reg == pfi_pkg::OP_INTEGRATE)
        begin
            vx_new = pfi_pkg::sat32(pfi_pkg::ext36(vel_x_reg) + pfi_pkg::ext36(frc_x_reg));
            vy_new = pfi_pkg::sat32(pfi_pkg::ext36(vel_y_reg) + pfi_pkg::ext36(frc_y_reg));
            px_new = pfi_pkg::sat32(pfi_pkg::ext36(pos_x_reg) + pfi_pkg::ext36(vx_new));
            py_new = pfi_pkg::sat32(pfi_pkg::ext36(pos_y_reg) + pfi_pkg::ext36(vy_new));
        end
        else if (op_reg == pfi_pkg::OP_TRAIL)
        begin
            px_new = trail_x[32:1];
            py_new = trail_y[32:1];
        end
    end

    // Particle state, configuration and result handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= pfi_pkg::GAIN_RESET;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            vel_x_reg     <= '0;
            vel_y_reg     <= '0;
            frc_x_reg     <= '0;
            frc_y_reg     <= '0;
            launched_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                gain_reg <= cfg_wdata;
            end

            if (mul_start || div_start || sqrt_start)
            begin
                launched_reg <= 1'b1;
            end
            else if (mul_done || div_done || sqrt_done)
            begin
                launched_reg <= 1'b0;
            end

            if (state_reg == pfi_pkg::ST_DAMPX && mul_done)
            begin
                frc_x_reg <= pfi_pkg::sat32(damp_sum);
            end
            if (state_reg == pfi_pkg::ST_DAMPY && mul_done)
            begin
                frc_y_reg <= pfi_pkg::sat32(damp_sum);
            end
            if (state_reg == pfi_pkg::ST_ACCUM)
            begin
                if (axis_reg)
                begin
                    frc_y_reg <= pfi_pkg::sat32(radial_sum);
                end
                else
                begin
                    frc_x_reg <= pfi_pkg::sat32(radial_sum);
                end
            end

            if (state_reg == pfi_pkg::ST_WRITE && out_free)
            begin
                pos_x_reg     <= px_new;
                pos_y_reg     <= py_new;
                vel_x_reg     <= vx_new;
                vel_y_reg     <= vy_new;
                if (!set_reg && op_reg == pfi_pkg::OP_CLEAR)
                begin
                    frc_x_reg <= '0;
                    frc_y_reg <= '0;
                end
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Command latch and working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            op_reg   <= cmd.opcode;
            set_reg  <= cmd.set_state;
            pt_x_reg <= cmd.point_x;
            pt_y_reg <= cmd.point_y;
            nv_x_reg <= cmd.new_vel_x;
            nv_y_reg <= cmd.new_vel_y;
            rad_reg  <= cmd.radius;
            str_reg  <= cmd.strength;
        end

        if (state_reg == pfi_pkg::ST_DECODE)
        begin
            dx_reg   <= dx_c;
            dy_reg   <= dy_c;
            hit_reg  <= 1'b0;
            axis_reg <= 1'b0;
        end

        if (mul_done)
        begin
            case (state_reg)
                pfi_pkg::ST_SQX:  ssum_reg <= mul_p[62:0];
                pfi_pkg::ST_SQY:  ssum_reg <= ssum_reg + mul_p[62:0];
                pfi_pkg::ST_SQR:  hit_reg  <= ssum_reg < mul_p[62:0];
                pfi_pkg::ST_MUL1: m_reg    <= mul_p[2*FRAC_BITS:FRAC_BITS];
                pfi_pkg::ST_MUL2: mag_reg  <= mul_p[FRAC_BITS+31:FRAC_BITS];
                default:          m_reg    <= m_reg;
            endcase
        end

        if (sqrt_done)
        begin
            dist_reg <= sqrt_root[30:0];
        end

        if (div_done)
        begin
            if (state_reg == pfi_pkg::ST_PCT)
            begin
                pct_reg <= div_q[QW-1:0];
            end
            else
            begin
                unit_reg <= div_q[QW-1:0];
            end
        end

        if (state_reg == pfi_pkg::ST_ACCUM)
        begin
            axis_reg <= 1'b1;
        end

        if (state_reg == pfi_pkg::ST_WRITE && out_free)
        begin
            out_px_reg  <= px_new;
            out_py_reg  <= py_new;
            out_vx_reg  <= vx_new;
            out_vy_reg  <= vy_new;
            out_hit_reg <= hit_reg;
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.pos_x    = out_px_reg;
    assign res.pos_y    = out_py_reg;
    assign res.vel_x    = out_vx_reg;
    assign res.vel_y    = out_vy_reg;
    assign res.in_range = out_hit_reg;
endmodule
